@@ design/wiper_interval_washer_controller_core_assert.svh @@
// Assertion macros for the wiper and washer controller core.
`ifndef WIPER_INTERVAL_WASHER_CONTROLLER_CORE_ASSERT_SVH
`define WIPER_INTERVAL_WASHER_CONTROLLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define WIWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WIWC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define WIWC_ASSERT(lbl, prop, msg)
`define WIWC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ design/wiwc_pkg.sv @@
// Types and constants of the wiper and washer controller.
package wiwc_pkg;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_AUTO  = 2'd1,
    MODE_INTER = 2'd2,
    MODE_CONT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_INTER_PAUSE = 2'd0,
    CFG_MAX_WASH    = 2'd1,
    CFG_WIPE_PULSE  = 2'd2
  } cfg_reg_t;

  localparam logic [9:0] SEL_STOP_ABOVE = 10'd1000;
  localparam logic [9:0] SEL_AUTO_TOP   = 10'd40;
  localparam logic [9:0] SEL_INTER_TOP  = 10'd25;
  localparam logic [9:0] SEL_CONT_TOP   = 10'd20;
  localparam logic [9:0] SEL_CONT_LOW   = 10'd10;

  localparam logic [15:0] RST_INTER_PAUSE = 16'd5000;
  localparam logic [15:0] RST_MAX_WASH    = 16'd5000;
  localparam logic [15:0] RST_WIPE_PULSE  = 16'd1000;

  typedef struct packed {
    logic [9:0]  selector_sample;
    logic        washer_button;
    logic        washer_remote;
    logic        remote_write;
    logic [1:0]  remote_mode;
    logic [15:0] remote_pause;
  } req_t;

  typedef struct packed {
    logic       wiper_relay;
    logic       washer_relay;
    logic [1:0] active_mode;
  } rsp_t;

endpackage

@@ design/wiper_interval_washer_controller_core.sv @@
// Wiper and washer controller: one millisecond tick beat in, one relay status beat out.
//
// Usage:
//   req channel (req_valid/req_stall/req_data): one beat per millisecond tick with
//   the selector sample, washer levels and an optional remote mode/pause write.
//   rsp channel (rsp_valid/rsp_stall/rsp_data): one beat per tick with the wiper
//   relay, washer relay and active mode after that tick.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): pause, wash limit and
//   wipe pulse registers; always ready, write only while idle.
// Result: an accepted tick's result is registered in the result or skid register.
// Throughput: one tick per cycle while req_stall is low; the whole tick update is one
//   combinational pass from the state registers into the state and result registers.
// Stall: a two-entry output (result register plus skid register) keeps ticks
//   flowing for one extra beat; req_stall rises only when both entries are full.
// Reset (rst, synchronous): modes stop, timers and relays zero, config registers
//   back to 5000/5000/1000 ms, output empty.
module wiper_interval_washer_controller_core #(
  parameter int TIMER_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  wiwc_pkg::req_t  req_data,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output wiwc_pkg::rsp_t  rsp_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data
);

  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  // config
  logic [15:0] intermittent_pause_ms;
  logic [15:0] max_wash_ms;
  logic [15:0] wipe_pulse_ms;

  // tick state
  wiwc_pkg::mode_t last_local_mode, last_local_mode_next;
  wiwc_pkg::mode_t last_remote_mode, last_remote_mode_next;
  wiwc_pkg::mode_t stored_remote_mode, stored_remote_mode_next;
  wiwc_pkg::mode_t mode_now, mode_now_next;
  logic [15:0] stored_remote_pause, stored_remote_pause_next;
  logic [15:0] pause_now, pause_now_next;
  logic wipers_enabled, wipers_enabled_next;
  logic remote_allowed, remote_allowed_next;
  logic interval_arm, interval_arm_next;
  logic interval_run, interval_run_next;
  logic wipe_start_pending, wipe_start_pending_next;
  logic wipe_stop_pending, wipe_stop_pending_next;
  logic [TIMER_BITS-1:0] interval_elapsed, interval_elapsed_next;
  logic [TIMER_BITS-1:0] wipe_elapsed, wipe_elapsed_next;
  logic [TIMER_BITS-1:0] wash_elapsed, wash_elapsed_next;
  logic prev_washer_button, prev_washer_button_next;
  logic prev_washer_remote, prev_washer_remote_next;
  logic wiper_out, wiper_out_next;
  logic washer_out, washer_out_next;

  // output stage
  logic           ov;
  logic           sv;
  wiwc_pkg::rsp_t skid;
  wiwc_pkg::rsp_t rsp_next;
  logic           push;
  logic           pop;

  wiwc_pkg::mode_t local_mode;
  logic            changed;

  function automatic wiwc_pkg::mode_t decode_selector(input logic [9:0] s);
    wiwc_pkg::mode_t m;
    if (s > wiwc_pkg::SEL_STOP_ABOVE) begin
      m = wiwc_pkg::MODE_STOP;
    end else if (s > wiwc_pkg::SEL_INTER_TOP && s <= wiwc_pkg::SEL_AUTO_TOP) begin
      m = wiwc_pkg::MODE_AUTO;
    end else if (s > wiwc_pkg::SEL_CONT_TOP && s <= wiwc_pkg::SEL_INTER_TOP) begin
      m = wiwc_pkg::MODE_INTER;
    end else if (s > wiwc_pkg::SEL_CONT_LOW && s <= wiwc_pkg::SEL_CONT_TOP) begin
      m = wiwc_pkg::MODE_CONT;
    end else begin
      m = wiwc_pkg::MODE_STOP;
    end
    return m;
  endfunction

  function automatic logic [TIMER_BITS-1:0] tick_timer(input logic [TIMER_BITS-1:0] t);
    return (t == TMAX) ? t : t + 1'b1;
  endfunction

  assign cfg_ready = 1'b1;
  assign req_stall = sv;
  assign push      = req_valid && !sv;
  assign pop       = ov && !rsp_stall;
  assign rsp_valid = ov;
  assign local_mode = decode_selector(req_data.selector_sample);

  always_comb begin
    interval_elapsed_next   = tick_timer(interval_elapsed);
    wipe_elapsed_next       = tick_timer(wipe_elapsed);
    wash_elapsed_next       = tick_timer(wash_elapsed);
    stored_remote_mode_next  = stored_remote_mode;
    stored_remote_pause_next = stored_remote_pause;
    last_local_mode_next    = last_local_mode;
    last_remote_mode_next   = last_remote_mode;
    mode_now_next           = mode_now;
    pause_now_next          = pause_now;
    wipers_enabled_next     = wipers_enabled;
    remote_allowed_next     = remote_allowed;
    interval_arm_next       = interval_arm;
    interval_run_next       = interval_run;
    wipe_start_pending_next = wipe_start_pending;
    wipe_stop_pending_next  = wipe_stop_pending;
    prev_washer_button_next = prev_washer_button;
    prev_washer_remote_next = prev_washer_remote;
    wiper_out_next          = wiper_out;
    washer_out_next         = washer_out;
    changed                 = 1'b0;

    if (req_data.remote_write && remote_allowed) begin
      stored_remote_mode_next  = wiwc_pkg::mode_t'(req_data.remote_mode);
      stored_remote_pause_next = req_data.remote_pause;
    end

    if (last_local_mode != local_mode) begin
      mode_now_next        = local_mode;
      last_local_mode_next = local_mode;
      changed              = 1'b1;
      case (local_mode)
        wiwc_pkg::MODE_AUTO: begin
          wipers_enabled_next = 1'b0;
          pause_now_next      = '0;
          remote_allowed_next = 1'b1;
        end
        wiwc_pkg::MODE_INTER: begin
          wipers_enabled_next = 1'b1;
          pause_now_next      = intermittent_pause_ms;
          remote_allowed_next = 1'b0;
        end
        wiwc_pkg::MODE_CONT: begin
          wipers_enabled_next = 1'b1;
          pause_now_next      = '0;
          remote_allowed_next = 1'b0;
        end
        default: begin
          wipers_enabled_next = 1'b0;
          remote_allowed_next = 1'b0;
        end
      endcase
    end else if (last_remote_mode != stored_remote_mode_next) begin
      mode_now_next         = stored_remote_mode_next;
      last_remote_mode_next = stored_remote_mode_next;
      changed               = 1'b1;
      case (stored_remote_mode_next)
        wiwc_pkg::MODE_INTER: begin
          wipers_enabled_next = 1'b1;
          pause_now_next      = stored_remote_pause_next;
        end
        wiwc_pkg::MODE_CONT: begin
          wipers_enabled_next = 1'b1;
          pause_now_next      = '0;
        end
        default: begin
          wipers_enabled_next = 1'b0;
        end
      endcase
    end

    if (changed) begin
      if (wipers_enabled_next && mode_now_next != wiwc_pkg::MODE_CONT) begin
        wipe_start_pending_next = 1'b1;
        interval_arm_next       = 1'b1;
      end else begin
        interval_arm_next = 1'b0;
        interval_run_next = 1'b0;
        wiper_out_next    = wipers_enabled_next;
      end
    end

    if (interval_arm_next) begin
      interval_elapsed_next = '0;
      interval_arm_next     = 1'b0;
      interval_run_next     = 1'b1;
    end
    if (interval_run_next && CW'(interval_elapsed_next) >= CW'(pause_now_next)) begin
      wipe_start_pending_next = 1'b1;
      interval_arm_next       = 1'b1;
    end

    if (wipe_start_pending_next) begin
      wiper_out_next          = 1'b1;
      wipe_elapsed_next       = '0;
      wipe_start_pending_next = 1'b0;
      wipe_stop_pending_next  = 1'b1;
    end
    if (wipe_stop_pending_next && CW'(wipe_elapsed_next) >= CW'(wipe_pulse_ms)) begin
      wiper_out_next         = 1'b0;
      wipe_stop_pending_next = 1'b0;
    end

    // button edge wins over a remote edge on the same tick
    if (prev_washer_button != req_data.washer_button) begin
      washer_out_next         = req_data.washer_button;
      prev_washer_button_next = req_data.washer_button;
      if (req_data.washer_button) begin
        wash_elapsed_next = '0;
      end
    end else if (prev_washer_remote != req_data.washer_remote) begin
      washer_out_next         = req_data.washer_remote;
      prev_washer_remote_next = req_data.washer_remote;
      if (req_data.washer_remote) begin
        wash_elapsed_next = '0;
      end
    end else if (req_data.washer_button && CW'(wash_elapsed_next) >= CW'(max_wash_ms)) begin
      washer_out_next = 1'b0;
    end

    rsp_next.wiper_relay  = wiper_out_next;
    rsp_next.washer_relay = washer_out_next;
    rsp_next.active_mode  = mode_now_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      intermittent_pause_ms <= wiwc_pkg::RST_INTER_PAUSE;
      max_wash_ms           <= wiwc_pkg::RST_MAX_WASH;
      wipe_pulse_ms         <= wiwc_pkg::RST_WIPE_PULSE;
    end else if (cfg_valid && cfg_ready) begin
      case (wiwc_pkg::cfg_reg_t'(cfg_index))
        wiwc_pkg::CFG_INTER_PAUSE: intermittent_pause_ms <= cfg_data;
        wiwc_pkg::CFG_MAX_WASH:    max_wash_ms           <= cfg_data;
        wiwc_pkg::CFG_WIPE_PULSE:  wipe_pulse_ms         <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_local_mode     <= wiwc_pkg::MODE_STOP;
      last_remote_mode    <= wiwc_pkg::MODE_STOP;
      stored_remote_mode  <= wiwc_pkg::MODE_STOP;
      mode_now            <= wiwc_pkg::MODE_STOP;
      stored_remote_pause <= '0;
      pause_now           <= '0;
      wipers_enabled      <= 1'b0;
      remote_allowed      <= 1'b0;
      interval_arm        <= 1'b0;
      interval_run        <= 1'b0;
      wipe_start_pending  <= 1'b0;
      wipe_stop_pending   <= 1'b0;
      interval_elapsed    <= '0;
      wipe_elapsed        <= '0;
      wash_elapsed        <= '0;
      prev_washer_button  <= 1'b0;
      prev_washer_remote  <= 1'b0;
      wiper_out           <= 1'b0;
      washer_out          <= 1'b0;
    end else if (push) begin
      last_local_mode     <= last_local_mode_next;
      last_remote_mode    <= last_remote_mode_next;
      stored_remote_mode  <= stored_remote_mode_next;
      mode_now            <= mode_now_next;
      stored_remote_pause <= stored_remote_pause_next;
      pause_now           <= pause_now_next;
      wipers_enabled      <= wipers_enabled_next;
      remote_allowed      <= remote_allowed_next;
      interval_arm        <= interval_arm_next;
      interval_run        <= interval_run_next;
      wipe_start_pending  <= wipe_start_pending_next;
      wipe_stop_pending   <= wipe_stop_pending_next;
      interval_elapsed    <= interval_elapsed_next;
      wipe_elapsed        <= wipe_elapsed_next;
      wash_elapsed        <= wash_elapsed_next;
      prev_washer_button  <= prev_washer_button_next;
      prev_washer_remote  <= prev_washer_remote_next;
      wiper_out           <= wiper_out_next;
      washer_out          <= washer_out_next;
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (pop) begin
        sv <= 1'b0;
      end
    end else if (push) begin
      if (ov && !pop) begin
        sv <= 1'b1;
      end else begin
        ov <= 1'b1;
      end
    end else if (pop) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (pop) begin
        rsp_data <= skid;
      end
    end else if (push) begin
      if (ov && !pop) begin
        skid <= rsp_next;
      end else begin
        rsp_data <= rsp_next;
      end
    end
  end

`include "wiper_interval_washer_controller_core_assert.svh"

  `WIWC_ASSERT(a_skid_needs_out, (sv |-> ov), "skid full while result register empty")
  `WIWC_ASSERT_NEXT(a_push_fills, push, ov, "accepted tick beat not held in output")
  `WIWC_ASSERT(a_no_start_left, (!wipe_start_pending), "wipe start left pending after a tick")
  `WIWC_ASSERT(a_wiper_hold, ((wiper_out && !wipe_stop_pending) |-> (mode_now == wiwc_pkg::MODE_CONT)), "wiper held on outside continuous mode")

endmodule
